### src/nff_pkg.sv
// shared types, constants and helper functions for the numeric field formatter
`default_nettype none
package nff_pkg;

    localparam int MAX_WIDTH  = 20;
    localparam int NUM_DIGITS = 11;
    localparam int DEC_DIGITS = 10;
    localparam int VAL_W      = 32;
    localparam int DAB_STEPS  = VAL_W / 2;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UPA   = 8'h41;

    typedef enum logic [1:0] {
        CMD_UDEC = 2'd0,
        CMD_OCT  = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_SDEC = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_SIZE,
        ST_EMIT
    } t_state;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    // one double-dabble step: correct every bcd digit, then shift in one bit
    function automatic logic [4*DEC_DIGITS-1:0] dabble_step(
        input logic [4*DEC_DIGITS-1:0] bcd,
        input logic                    bit_in
    );
        logic [4*DEC_DIGITS-1:0] adj;
        adj = bcd;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {adj[4*DEC_DIGITS-2:0], bit_in};
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_UPA + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### src/nff_conv.sv
// digit conversion: bit slicing for octal and hex, two-bit-per-cycle double dabble for decimal
`default_nettype none
module nff_conv (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire  [31:0]             i_mag,
    input  wire  [1:0]              i_cmd,
    output nff_pkg::t_digits        o_digits,
    output logic                    o_done
);

    logic [nff_pkg::VAL_W-1:0]          r_bin, n_bin;
    logic [4*nff_pkg::NUM_DIGITS-1:0]   r_dig, n_dig;
    logic [3:0]                         r_cnt, n_cnt;
    logic                               r_run, n_run;
    logic                               r_done, n_done;
    logic [4*nff_pkg::NUM_DIGITS-1:0]   w_slice;
    logic [4*nff_pkg::DEC_DIGITS-1:0]   w_step1, w_step2;
    logic                               w_dec;

    assign w_dec = (nff_pkg::t_cmd'(i_cmd) == nff_pkg::CMD_UDEC) ||
                   (nff_pkg::t_cmd'(i_cmd) == nff_pkg::CMD_SDEC);

    always_comb begin
        w_slice = '0;
        if (nff_pkg::t_cmd'(i_cmd) == nff_pkg::CMD_HEX) begin
            w_slice[31:0] = i_mag;
        end else begin
            // octal digits widened to nibbles
            for (int i = 0; i < 10; i++) begin
                w_slice[4*i +: 4] = {1'b0, i_mag[3*i +: 3]};
            end
            w_slice[43:40] = {2'b00, i_mag[31:30]};
        end
    end

    assign w_step1 = nff_pkg::dabble_step(r_dig[4*nff_pkg::DEC_DIGITS-1:0], r_bin[31]);
    assign w_step2 = nff_pkg::dabble_step(w_step1, r_bin[30]);

    always_comb begin
        n_bin  = r_bin;
        n_dig  = r_dig;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_load) begin
            n_bin  = i_mag;
            n_cnt  = '0;
            n_run  = w_dec;
            n_done = !w_dec;
            n_dig  = w_dec ? '0 : w_slice;
        end else if (r_run) begin
            n_bin = {r_bin[29:0], 2'b00};
            n_dig = {4'd0, w_step2};
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'(nff_pkg::DAB_STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_dig <= n_dig;
    end

    assign o_digits = r_dig;
    assign o_done   = r_done;

endmodule
`default_nettype wire

### src/numeric_field_formatter.sv
// top level: integer field formatter emitting one ascii character per cycle
//
// usage: present value and format on the i_ ports and raise i_start while
// o_busy is low; that edge takes the beat. o_busy drops in the cycle that
// carries the last character of the field.
// each character appears on o_out_char for exactly one cycle with o_valid
// high; o_last_char marks the final one. the receiver cannot stall the
// output, every o_valid cycle is a delivered character.
// sequence: decimal conversion runs two bits per cycle through the
// double-dabble unit and then hands the digits over, octal and hex take
// one slicing step. then the count state finds the digit count and the
// size state sizes the field, after which the field leaves at one
// character per cycle; a field is 1 to 20 characters wide.
// reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; a field in progress is discarded.
`default_nettype none
module numeric_field_formatter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [31:0] i_value,
    input  wire  [1:0]  i_command,
    input  wire  [4:0]  i_field_width,
    input  wire         i_zero_fill,
    input  wire         i_force_plus,
    output logic        o_valid,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    nff_pkg::t_state    r_state, n_state;
    logic [4:0]         r_fw;
    logic               r_zfill;
    logic               r_sign;
    logic               r_neg;
    logic [3:0]         r_nd;
    logic [4:0]         r_width;
    logic               r_ovf;
    logic [4:0]         r_pos, n_pos;
    logic               r_valid, n_valid;
    logic [7:0]         r_char, n_char;
    logic               r_last, n_last;

    logic               w_accept;
    logic               w_signed;
    logic               w_neg;
    logic [31:0]        w_mag;
    nff_pkg::t_digits   w_digits;
    logic               w_done;
    logic [3:0]         w_nd;
    logic [4:0]         w_need;
    logic [4:0]         w_width;
    logic [4:0]         w_k;

    assign w_accept = i_start && !o_busy;
    assign w_signed = nff_pkg::t_cmd'(i_command) == nff_pkg::CMD_SDEC;
    assign w_neg    = w_signed && i_value[31];
    assign w_mag    = w_neg ? (32'd0 - i_value) : i_value;

    nff_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_mag    (w_mag),
        .i_cmd    (i_command),
        .o_digits (w_digits),
        .o_done   (w_done)
    );

    // highest nonzero digit, at least one digit
    always_comb begin
        w_nd = 4'd1;
        for (int i = 1; i < nff_pkg::NUM_DIGITS; i++) begin
            if (w_digits[i] != 4'd0) begin
                w_nd = 4'(i + 1);
            end
        end
    end

    always_comb begin
        w_need = {1'b0, r_nd} + {4'd0, r_sign};
        if (r_fw == 5'd0) begin
            w_width = w_need;
        end else if (r_fw > 5'(nff_pkg::MAX_WIDTH)) begin
            w_width = 5'(nff_pkg::MAX_WIDTH);
        end else begin
            w_width = r_fw;
        end
    end

    assign w_k = r_width - 5'd1 - r_pos;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nff_pkg::ST_IDLE:  if (w_accept) n_state = nff_pkg::ST_CONV;
            nff_pkg::ST_CONV:  if (w_done) n_state = nff_pkg::ST_COUNT;
            nff_pkg::ST_COUNT: n_state = nff_pkg::ST_SIZE;
            nff_pkg::ST_SIZE:  n_state = nff_pkg::ST_EMIT;
            nff_pkg::ST_EMIT:  if (r_pos == r_width - 5'd1) n_state = nff_pkg::ST_IDLE;
            default:           n_state = nff_pkg::ST_IDLE;
        endcase
    end

    // character output
    always_comb begin
        n_pos   = r_pos;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = 1'b0;
        case (r_state)
            nff_pkg::ST_SIZE: begin
                n_pos = '0;
            end
            nff_pkg::ST_EMIT: begin
                n_pos   = r_pos + 5'd1;
                n_valid = 1'b1;
                n_last  = (r_pos == r_width - 5'd1);
                if (r_ovf) begin
                    n_char = nff_pkg::CH_STAR;
                end else if (w_k < {1'b0, r_nd}) begin
                    n_char = nff_pkg::digit_char(w_digits[w_k[3:0]]);
                end else if (r_sign && ((r_zfill && r_pos == 5'd0) ||
                                        (!r_zfill && w_k == {1'b0, r_nd}))) begin
                    n_char = r_neg ? nff_pkg::CH_MINUS : nff_pkg::CH_PLUS;
                end else begin
                    n_char = r_zfill ? nff_pkg::CH_ZERO : nff_pkg::CH_SPACE;
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nff_pkg::ST_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
            r_pos   <= n_pos;
        end
        r_char <= n_char;
        if (w_accept) begin
            r_fw    <= i_field_width;
            r_zfill <= i_zero_fill;
            r_neg   <= w_neg;
            r_sign  <= w_neg || (w_signed && i_force_plus);
        end
        if (r_state == nff_pkg::ST_COUNT) begin
            r_nd <= w_nd;
        end
        if (r_state == nff_pkg::ST_SIZE) begin
            r_width <= w_width;
            r_ovf   <= w_need > w_width;
        end
    end

    assign o_busy      = r_state != nff_pkg::ST_IDLE;
    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule
`default_nettype wire

### tb/sv/numeric_field_formatter_test.sv
// self-checking testbench for the numeric field formatter: directed and random formats
module numeric_field_formatter_test;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 270;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 48;   // longer than a full decimal field

    localparam logic [31:0] CORNER_VALUES [14] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0007, 32'h0000_0008,
        32'h0000_0009, 32'h0000_000A, 32'h0000_000F, 32'h0000_0010,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
        32'd999999999, 32'd1000000000
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_field_char;

    class format_scoreboard;
        t_field_char field_chars [$];
        int errors        = 0;
        int chars_checked = 0;
        int star_fields   = 0;
        int per_cmd [4]   = '{0, 0, 0, 0};

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        // builds the expected characters of one accepted format
        function void note_format(logic [31:0] value, nff_pkg::t_cmd cmd, logic [4:0] fw,
                                  logic zf, logic fp);
            string       glyphs   = "0123456789ABCDEF";
            logic [31:0] radix    = 32'd10;
            logic [31:0] mag      = value;
            logic [31:0] rest;
            logic [7:0]  sign_ch  = nff_pkg::CH_PLUS;
            logic [7:0]  text [nff_pkg::MAX_WIDTH];
            int          sign_pos = 0;
            int          ndig     = 1;
            int          wid;
            case (cmd)
                nff_pkg::CMD_OCT: radix = 32'd8;
                nff_pkg::CMD_HEX: radix = 32'd16;
                nff_pkg::CMD_SDEC: begin
                    if (value[31]) begin
                        mag      = -value;
                        sign_pos = 1;
                        sign_ch  = nff_pkg::CH_MINUS;
                    end else if (fp) begin
                        sign_pos = 1;
                    end
                end
                default: ;
            endcase
            rest = mag;
            while (rest >= radix) begin
                rest = rest / radix;
                ndig++;
            end
            wid = (fw == 5'd0) ? ndig + sign_pos : int'(fw);
            if (wid > nff_pkg::MAX_WIDTH) begin
                wid = nff_pkg::MAX_WIDTH;
            end
            per_cmd[cmd]++;
            if (ndig + sign_pos > wid) begin
                star_fields++;
                for (int i = 0; i < wid; i++) begin
                    text[i] = nff_pkg::CH_STAR;
                end
            end else begin
                for (int i = 0; i < wid; i++) begin
                    text[i] = zf ? nff_pkg::CH_ZERO : nff_pkg::CH_SPACE;
                end
                rest = mag;
                for (int i = 0; i < ndig; i++) begin
                    text[wid - 1 - i] = glyphs[rest % radix];
                    rest = rest / radix;
                end
                // zero fill puts the sign in column 0, space fill next to the digits
                if (sign_pos != 0) begin
                    text[zf ? 0 : wid - ndig - 1] = sign_ch;
                end
            end
            for (int i = 0; i < wid; i++) begin
                field_chars.push_back('{ch: text[i], last: (i == wid - 1)});
            end
        endfunction

        task check_char(logic [7:0] ch, logic last);
            t_field_char want;
            if (field_chars.size() == 0) begin
                report($sformatf("unexpected character 0x%02h", ch));
                return;
            end
            want = field_chars.pop_front();
            chars_checked++;
            if (ch !== want.ch) begin
                report($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
            end
            if (last !== want.last) begin
                report($sformatf("last_char %b, want %b", last, want.last));
            end
        endtask

        function int pending();
            return field_chars.size();
        endfunction

        task close_out();
            if (field_chars.size() != 0) begin
                report($sformatf("%0d characters never arrived", field_chars.size()));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [31:0] i_value;
    logic [1:0]  i_command;
    logic [4:0]  i_field_width;
    logic        i_zero_fill;
    logic        i_force_plus;
    logic        o_valid;
    logic [7:0]  o_out_char;
    logic        o_last_char;

    format_scoreboard sb = new();
    int max_gap = 18;

    numeric_field_formatter u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_value      (i_value),
        .i_command    (i_command),
        .i_field_width(i_field_width),
        .i_zero_fill  (i_zero_fill),
        .i_force_plus (i_force_plus),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_char(o_out_char, o_last_char);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_format(logic [31:0] v, nff_pkg::t_cmd c, logic [4:0] w, logic z,
                               logic p);
        int gap;
        logic taken;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start       <= 1'b1;
        i_value       <= v;
        i_command     <= c;
        i_field_width <= w;
        i_zero_fill   <= z;
        i_force_plus  <= p;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_busy) begin
                taken = 1'b1;
                sb.note_format(v, c, w, z, p);
            end
        end
        @(negedge i_clk);
    endtask

    task automatic random_format();
        logic [31:0] v;
        logic [4:0]  w;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom();
            3:       v = $urandom_range(0, 20);
            4:       v = CORNER_VALUES[$urandom_range(0, 13)];
            5:       v = -$urandom_range(1, 100);
            6:       v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            default: v = $urandom() >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: w = 5'd0;
            3:       w = 5'($urandom_range(21, 31));
            default: w = 5'($urandom_range(1, 20));
        endcase
        send_format(v, nff_pkg::t_cmd'($urandom_range(0, 3)), w, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
    endtask

    // hold the sender off until every expected character has come out
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        i_start <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        #(2 * HALF_PERIOD * 300000);
        $display("timeout with %0d characters outstanding", sb.pending());
        $display("numeric_field_formatter_test failed");
        $finish;
    end

    initial begin
        int n;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_value       = '0;
        i_command     = nff_pkg::CMD_UDEC;
        i_field_width = '0;
        i_zero_fill   = 1'b0;
        i_force_plus  = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_format(32'h0000_0000, nff_pkg::CMD_UDEC, 5'd0,  1'b0, 1'b0);
        send_format(32'hFFFF_FFFF, nff_pkg::CMD_UDEC, 5'd0,  1'b0, 1'b1);
        send_format(32'hFFFF_FFFF, nff_pkg::CMD_OCT,  5'd0,  1'b1, 1'b0);
        send_format(32'hFFFF_FFFF, nff_pkg::CMD_HEX,  5'd0,  1'b0, 1'b0);
        send_format(32'hABCD_EF01, nff_pkg::CMD_HEX,  5'd10, 1'b1, 1'b0);
        // most negative value, in full, padded and too narrow
        send_format(32'h8000_0000, nff_pkg::CMD_SDEC, 5'd0,  1'b0, 1'b0);
        send_format(32'h8000_0000, nff_pkg::CMD_SDEC, 5'd20, 1'b1, 1'b0);
        send_format(32'h8000_0000, nff_pkg::CMD_SDEC, 5'd11, 1'b0, 1'b1);
        send_format(32'h8000_0000, nff_pkg::CMD_SDEC, 5'd10, 1'b0, 1'b0);
        send_format(32'h7FFF_FFFF, nff_pkg::CMD_SDEC, 5'd0,  1'b0, 1'b1);
        // one-char signed field of zero: a forced plus overflows, zero fill without sign fits
        send_format(32'h0000_0000, nff_pkg::CMD_SDEC, 5'd1,  1'b0, 1'b1);
        send_format(32'h0000_0000, nff_pkg::CMD_SDEC, 5'd1,  1'b1, 1'b0);
        send_format(-32'd5,        nff_pkg::CMD_SDEC, 5'd6,  1'b1, 1'b0);
        send_format(-32'd5,        nff_pkg::CMD_SDEC, 5'd6,  1'b0, 1'b0);
        send_format(32'd42,        nff_pkg::CMD_SDEC, 5'd5,  1'b1, 1'b1);
        send_format(32'd12345,     nff_pkg::CMD_UDEC, 5'd3,  1'b0, 1'b0);
        // widths above the maximum clamp
        send_format(32'd7,         nff_pkg::CMD_UDEC, 5'd31, 1'b1, 1'b0);
        send_format(32'd8,         nff_pkg::CMD_OCT,  5'd31, 1'b0, 1'b1);
        send_format(32'h0000_0000, nff_pkg::CMD_HEX,  5'd1,  1'b0, 1'b1);
        send_format(32'd1000000000, nff_pkg::CMD_UDEC, 5'd0, 1'b1, 1'b0);
        send_format(32'hFFFF_FFFF, nff_pkg::CMD_SDEC, 5'd2,  1'b0, 1'b1);
        send_format(32'h1234_5678, nff_pkg::CMD_HEX,  5'd8,  1'b1, 1'b1);
        send_format(32'h0000_0000, nff_pkg::CMD_OCT,  5'd20, 1'b1, 1'b1);
        send_format(32'h8000_0001, nff_pkg::CMD_SDEC, 5'd31, 1'b0, 1'b1);
        wait_for_drain();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // alternate stretches of back-to-back beats and random gaps
            if (n % 45 == 0) begin
                max_gap = ((n / 45) % 2 == 1) ? 0 : 18;
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_for_drain();
            end
            random_format();
        end
        wait_for_drain();
        sb.close_out();

        $display("covered %0d unsigned dec, %0d octal, %0d hex, %0d signed dec fields",
                 sb.per_cmd[nff_pkg::CMD_UDEC], sb.per_cmd[nff_pkg::CMD_OCT],
                 sb.per_cmd[nff_pkg::CMD_HEX], sb.per_cmd[nff_pkg::CMD_SDEC]);
        $display("%0d overflowed, %0d characters checked, %0d mismatches",
                 sb.star_fields, sb.chars_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("numeric_field_formatter_test passed");
        end else begin
            $display("numeric_field_formatter_test failed");
        end
        $finish;
    end

endmodule
